FILE: rtl/bcd_add_multiply_unit_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef BCD_ADD_MULTIPLY_UNIT_MACROS_SVH
`define BCD_ADD_MULTIPLY_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BAM_ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BAM_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bam_pkg.sv
package bam_pkg;

  localparam int DIGIT_W        = 4;
  localparam int OPERAND_W      = 32;
  localparam int RESULT_W       = 64;
  localparam int SIG_W          = 5;
  localparam int PROD_W         = 7;   // 9 * 9 = 81
  localparam int SUM_W          = 5;   // 9 + 9 = 18
  localparam int COL_W          = 10;  // column sum plus incoming carry stays below 1024
  localparam int CARRY_W        = 7;   // quotient of a column value by ten
  localparam int RADIX          = 10;
  localparam int MAX_DIGIT      = 9;
  localparam int COLS_PER_STAGE = 4;   // carry columns resolved per pipeline stage
  localparam int RECIP_MUL      = 205; // 205 / 2048 approximates 1/10
  localparam int RECIP_SHIFT    = 11;

  typedef struct packed {
    logic                 mode;
    logic [OPERAND_W-1:0] first_bcd;
    logic [OPERAND_W-1:0] second_bcd;
  } operand_t;

  typedef struct packed {
    logic [RESULT_W-1:0] result_bcd;
    logic [SIG_W-1:0]    significant_digits;
    logic                bad_digit;
  } result_t;

  // Quotient by ten, exact for every value below 1024.
  function automatic logic [CARRY_W-1:0] div10(input logic [COL_W-1:0] v);
    logic [COL_W+7:0] prod;
    prod = (COL_W + 8)'(v) * (COL_W + 8)'(RECIP_MUL);
    return CARRY_W'(prod >> RECIP_SHIFT);
  endfunction

endpackage

FILE: rtl/bam_if.sv
interface bam_operand_if import bam_pkg::*; ;
  logic     valid;
  logic     ready;
  operand_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bam_result_if import bam_pkg::*; ;
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/bam_digit_mult.sv
module bam_digit_mult import bam_pkg::*; #(
  parameter int DIGITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  operand_t                               in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_mode,
  output logic                                   out_bad,
  output logic [DIGITS-1:0][DIGITS-1:0][PROD_W-1:0] out_prod,
  output logic [DIGITS-1:0][SUM_W-1:0]           out_sum
);

  logic [DIGITS-1:0][DIGIT_W-1:0]              a_dig;
  logic [DIGITS-1:0][DIGIT_W-1:0]              b_dig;
  logic                                        bad_next;
  logic [DIGITS-1:0][DIGITS-1:0][PROD_W-1:0]   prod_next;
  logic [DIGITS-1:0][SUM_W-1:0]                sum_next;

  assign in_ready = !out_valid || out_ready;

  // Split the operands; nibbles above DIGITS play no part.
  always_comb begin
    bad_next = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      a_dig[i] = in_data.first_bcd[DIGIT_W*i +: DIGIT_W];
      b_dig[i] = in_data.second_bcd[DIGIT_W*i +: DIGIT_W];
      if (a_dig[i] > DIGIT_W'(MAX_DIGIT) || b_dig[i] > DIGIT_W'(MAX_DIGIT)) begin
        bad_next = 1'b1;
      end
      sum_next[i] = SUM_W'(a_dig[i]) + SUM_W'(b_dig[i]);
    end
    for (int i = 0; i < DIGITS; i++) begin
      for (int j = 0; j < DIGITS; j++) begin
        prod_next[i][j] = PROD_W'(a_dig[i]) * PROD_W'(b_dig[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_mode <= in_data.mode;
      out_bad  <= bad_next;
      out_prod <= prod_next;
      out_sum  <= sum_next;
    end
  end

endmodule

FILE: rtl/bam_column_sum.sv
module bam_column_sum import bam_pkg::*; #(
  parameter int DIGITS = 8,
  parameter int RES    = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_mode,
  input  logic                                     in_bad,
  input  logic [DIGITS-1:0][DIGITS-1:0][PROD_W-1:0] in_prod,
  input  logic [DIGITS-1:0][SUM_W-1:0]             in_sum,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     out_bad,
  output logic [RES-1:0][COL_W-1:0]                out_cols
);

  logic [RES-1:0][COL_W-1:0] cols_next;
  logic [COL_W-1:0]          acc;

  assign in_ready = !out_valid || out_ready;

  // Gather each column: the digit sum in add mode, the diagonal of products in
  // multiply mode; zero everything on a bad digit.
  always_comb begin
    acc = '0;
    for (int k = 0; k < RES; k++) begin
      acc = '0;
      if (!in_mode) begin
        if (k < DIGITS) begin
          acc = COL_W'(in_sum[k]);
        end
      end else begin
        for (int i = 0; i < DIGITS; i++) begin
          if (k >= i && k - i < DIGITS) begin
            acc = acc + COL_W'(in_prod[i][k-i]);
          end
        end
      end
      if (in_bad) begin
        acc = '0;
      end
      cols_next[k] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bad  <= in_bad;
      out_cols <= cols_next;
    end
  end

endmodule

FILE: rtl/bam_carry_stage.sv
module bam_carry_stage import bam_pkg::*; #(
  parameter int RES  = 16,
  parameter int BASE = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_bad,
  input  logic [RES-1:0][COL_W-1:0] in_cols,
  input  logic [CARRY_W-1:0]        in_carry,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_bad,
  output logic [RES-1:0][COL_W-1:0] out_cols,
  output logic [CARRY_W-1:0]        out_carry
);

  logic [RES-1:0][COL_W-1:0] cols_next;
  logic [CARRY_W-1:0]        carry;
  logic [COL_W-1:0]          v;
  logic [CARRY_W-1:0]        q;

  assign in_ready = !out_valid || out_ready;

  // Resolve a slice of columns into decimal digits, rippling the carry.
  always_comb begin
    cols_next = in_cols;
    carry     = in_carry;
    v         = '0;
    q         = '0;
    for (int k = 0; k < COLS_PER_STAGE; k++) begin
      if (BASE + k < RES) begin
        v = in_cols[BASE+k] + COL_W'(carry);
        q = div10(v);
        cols_next[BASE+k] = v - COL_W'(q) * COL_W'(RADIX);
        carry = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bad   <= in_bad;
      out_cols  <= cols_next;
      out_carry <= carry;
    end
  end

endmodule

FILE: rtl/bam_digit_count.sv
module bam_digit_count import bam_pkg::*; #(
  parameter int RES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_bad,
  input  logic [RES-1:0][COL_W-1:0] in_cols,
  output logic                      out_valid,
  input  logic                      out_ready,
  output result_t                   out_data
);

  result_t data_next;

  assign in_ready = !out_valid || out_ready;

  // Pack the digits and find the highest nonzero one.
  always_comb begin
    data_next.result_bcd         = '0;
    data_next.significant_digits = SIG_W'(1);
    data_next.bad_digit          = in_bad;
    for (int k = 0; k < RES; k++) begin
      data_next.result_bcd[DIGIT_W*k +: DIGIT_W] = in_cols[k][DIGIT_W-1:0];
      if (in_cols[k][DIGIT_W-1:0] != '0) begin
        data_next.significant_digits = SIG_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: rtl/bcd_add_multiply_unit.sv
// Packed-BCD adder and multiplier. Each transaction on the operands channel
// carries two unsigned decimal numbers of DIGITS BCD digits (least significant
// digit in the low nibble) and a mode bit: 0 adds, 1 forms the full product.
// Each transaction on the results channel returns the packed BCD result, the
// count of significant digits (1 for zero) and a bad-digit flag, raised when
// any used operand nibble exceeds 9, in which case the result is zero.
// Operand nibbles above DIGITS are ignored. The unit is a fully pipelined
// valid/ready chain: it takes one transaction per cycle while the results
// channel does not stall it, and returns results in order. Its depth is set
// by the decimal carry ripple, which resolves four result columns per stage.
// Each stage holds its data under back-pressure and fills bubbles
// independently, so new operands enter while a result waits.
`include "bcd_add_multiply_unit_macros.svh"

module bcd_add_multiply_unit import bam_pkg::*; #(
  parameter int DIGITS = 8
) (
  input logic          clk,
  input logic          rst,
  bam_operand_if.sink  operands,
  bam_result_if.source results
);

  localparam int RES  = 2 * DIGITS;
  localparam int NSTG = (RES + COLS_PER_STAGE - 1) / COLS_PER_STAGE;

  // Stage 1: digit products and digit sums.
  logic                                      s1_valid;
  logic                                      s1_ready;
  logic                                      s1_mode;
  logic                                      s1_bad;
  logic [DIGITS-1:0][DIGITS-1:0][PROD_W-1:0] s1_prod;
  logic [DIGITS-1:0][SUM_W-1:0]              s1_sum;

  // Carry chain: index 0 is the column-sum stage output, index NSTG the
  // fully resolved digits.
  logic [NSTG:0]                      ch_valid;
  logic [NSTG:0]                      ch_ready;
  logic [NSTG:0]                      ch_bad;
  logic [NSTG:0][RES-1:0][COL_W-1:0]  ch_cols;
  logic [NSTG:0][CARRY_W-1:0]         ch_carry;

  bam_digit_mult #(
    .DIGITS (DIGITS)
  ) u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .in_data   (operands.payload),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_mode  (s1_mode),
    .out_bad   (s1_bad),
    .out_prod  (s1_prod),
    .out_sum   (s1_sum)
  );

  // Stage 2: collapse products along each diagonal (digit sums in add mode) into column totals.
  bam_column_sum #(
    .DIGITS (DIGITS),
    .RES    (RES)
  ) u_colsum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_mode   (s1_mode),
    .in_bad    (s1_bad),
    .in_prod   (s1_prod),
    .in_sum    (s1_sum),
    .out_valid (ch_valid[0]),
    .out_ready (ch_ready[0]),
    .out_bad   (ch_bad[0]),
    .out_cols  (ch_cols[0])
  );

  // No carry enters the lowest column.
  assign ch_carry[0] = '0;

  // Carry stages: each turns up to four column totals into digits and hands the
  // running carry to the next.
  for (genvar s = 0; s < NSTG; s++) begin : g_carry
    bam_carry_stage #(
      .RES  (RES),
      .BASE (s * COLS_PER_STAGE)
    ) u_carry (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (ch_valid[s]),
      .in_ready  (ch_ready[s]),
      .in_bad    (ch_bad[s]),
      .in_cols   (ch_cols[s]),
      .in_carry  (ch_carry[s]),
      .out_valid (ch_valid[s+1]),
      .out_ready (ch_ready[s+1]),
      .out_bad   (ch_bad[s+1]),
      .out_cols  (ch_cols[s+1]),
      .out_carry (ch_carry[s+1])
    );
  end

  // Final stage: pack digits, count significant digits; this is the output
  // register of the results channel.
  bam_digit_count #(
    .RES (RES)
  ) u_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ch_valid[NSTG]),
    .in_ready  (ch_ready[NSTG]),
    .in_bad    (ch_bad[NSTG]),
    .in_cols   (ch_cols[NSTG]),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.payload)
  );

  // A sum or product always fits in 2*DIGITS digits, so nothing carries out.
  `BAM_ASSERT_IMPLIES(a_no_carry_out, clk, rst, ch_valid[NSTG], ch_carry[NSTG] == '0, "carry out of top column")
  // A bad digit forces a zero result with one significant digit.
  `BAM_ASSERT_IMPLIES(a_bad_is_zero, clk, rst, results.valid && results.payload.bad_digit, results.payload.result_bcd == '0 && results.payload.significant_digits == SIG_W'(1), "bad digit with nonzero result")
  // Digit count stays within the result width.
  `BAM_ASSERT_IMPLIES(a_sig_range, clk, rst, results.valid, results.payload.significant_digits != '0 && results.payload.significant_digits <= SIG_W'(RES), "significant digit count out of range")
  // Hold resolved digits while the output stage is full and stalled.
  `BAM_ASSERT_NEXT(a_chain_hold, clk, rst, ch_valid[NSTG] && !ch_ready[NSTG], ch_valid[NSTG] && $stable(ch_cols[NSTG]), "stalled stage lost its data")

endmodule
